>>> design/bitmap_set_operation_filter_unit_macros.svh
// Assertion macros used by the checker module of the filter unit.
`ifndef BITMAP_SET_OPERATION_FILTER_UNIT_MACROS_SVH
`define BITMAP_SET_OPERATION_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge.
`define BSOF_ASSERT_IMPLIES(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge.
`define BSOF_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/bsof_pkg.sv
package bsof_pkg;

  localparam int VALUE_RANGE = 1024;

  localparam int KIND_W  = 2;
  localparam int MODE_W  = 2;
  localparam int VALUE_W = 10;
  localparam int POS_W   = 11;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_PAD_W   = OUT_TDATA_W - VALUE_W - POS_W;

  // Bitmap geometry: entries are grouped into rows, one valid flag per row.
  localparam int IDX_W       = $clog2(VALUE_RANGE);
  localparam int ROW_ENTRIES = (VALUE_RANGE >= 1024) ? VALUE_RANGE / 128 : 8;
  localparam int ROWS        = VALUE_RANGE / ROW_ENTRIES;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int COL_W       = $clog2(ROW_ENTRIES);

  typedef logic [KIND_W-1:0] kind_t;
  typedef logic [MODE_W-1:0] mode_t;

  localparam kind_t KIND_CLEAR = 2'd0;
  localparam kind_t KIND_B     = 2'd1;
  localparam kind_t KIND_A     = 2'd2;

  localparam mode_t MODE_INTERSECT = 2'd0;
  localparam mode_t MODE_UNION     = 2'd1;
  localparam mode_t MODE_DIFF      = 2'd2;

  typedef logic [ROW_ENTRIES-1:0] row_bits_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
  } row_rd_t;

  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] row;
    row_bits_t        b;
    row_bits_t        e;
  } row_wr_t;

endpackage

>>> design/bsof_row_store.sv
module bsof_row_store (
  input  logic               clk,
  input  logic               rst,
  input  bsof_pkg::row_rd_t  rd,
  input  bsof_pkg::row_wr_t  wr,
  input  logic               clear,
  output bsof_pkg::row_bits_t rd_b,
  output bsof_pkg::row_bits_t rd_e
);
  import bsof_pkg::*;

  row_bits_t        b_mem [ROWS];
  row_bits_t        e_mem [ROWS];
  row_bits_t        b_q;
  row_bits_t        e_q;
  logic [ROW_W-1:0] rd_row_q;

  logic [ROWS-1:0]  row_valid;
  logic             fwd_valid;
  logic [ROW_W-1:0] fwd_row;
  row_bits_t        fwd_b;
  row_bits_t        fwd_e;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      b_mem[wr.row] <= wr.b;
      e_mem[wr.row] <= wr.e;
    end
    if (rd.en) begin
      b_q      <= b_mem[rd.row];
      e_q      <= e_mem[rd.row];
      rd_row_q <= rd.row;
    end
  end

  // A row that was not written since the last clear reads as all zeros.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (wr.en) begin
      row_valid[wr.row] <= 1'b1;
      fwd_valid         <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fwd_row <= wr.row;
      fwd_b   <= wr.b;
      fwd_e   <= wr.e;
    end
  end

  // The read issued at the same edge as the last write missed it, so that
  // write is taken from the bypass register instead.
  always_comb begin
    if (fwd_valid && (fwd_row == rd_row_q)) begin
      rd_b = fwd_b;
      rd_e = fwd_e;
    end else if (row_valid[rd_row_q]) begin
      rd_b = b_q;
      rd_e = e_q;
    end else begin
      rd_b = '0;
      rd_e = '0;
    end
  end

endmodule

>>> design/bitmap_set_operation_filter_unit.sv
// Channel  | Direction | Handshake                    | Payload
// s_axis   | in        | s_axis_tvalid/s_axis_tready  | tuser: kind; tdata: element_value
// m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata: result_value, result_position
// cfg      | in        | cfg_valid/cfg_ready          | cfg_data: operation_mode
//
// One item per cycle while no result is held off. The bitmap row read is issued at
// the input transfer; the edge at which the row stage moves on writes the row back
// and loads the result register. A bypass register serves an item whose row read
// is issued at the edge where the item ahead writes that row back. Reset is
// synchronous; a clear item empties the bitmaps at once through per-row valid flags.
// A result that is not taken holds the input once the row stage is full.
module bitmap_set_operation_filter_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [9:0] element_value, [15:10] zero
  input  logic [bsof_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [1:0] kind
  input  logic [bsof_pkg::KIND_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [9:0] result_value, [20:10] result_position, [23:21] zero
  output logic [bsof_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bsof_pkg::MODE_W-1:0]       cfg_data
);
  import bsof_pkg::*;

  mode_t              mode;
  logic [POS_W-1:0]   count;

  logic               s1_valid;
  kind_t              s1_kind;
  logic [VALUE_W-1:0] s1_value;

  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic [POS_W-1:0]   out_pos;

  logic               s1_go;
  logic               in_accept;
  logic               s1_fire;
  logic [IDX_W-1:0]   in_idx;
  logic [IDX_W-1:0]   s1_idx;
  logic [COL_W-1:0]   s1_col;
  logic               s1_in_range;
  row_bits_t          rd_b;
  row_bits_t          rd_e;
  row_bits_t          col_mask;
  logic               hit_b;
  logic               hit_e;
  logic               mark_b;
  logic               pass;
  logic               emit;
  logic               clear;
  row_rd_t            rd;
  row_wr_t            wr;

  assign cfg_ready     = 1'b1;
  assign s1_go         = !out_valid || m_axis_tready;
  assign s_axis_tready = !s1_valid || s1_go;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s1_fire       = s1_valid && s1_go;

  assign in_idx  = IDX_W'(s_axis_tdata[VALUE_W-1:0]);
  assign rd.en   = in_accept;
  assign rd.row  = in_idx[IDX_W-1:COL_W];

  assign s1_idx      = IDX_W'(s1_value);
  assign s1_col      = s1_idx[COL_W-1:0];
  assign s1_in_range = (32'(s1_value) < 32'(VALUE_RANGE));
  assign col_mask    = row_bits_t'(1) << s1_col;
  assign hit_b       = rd_b[s1_col];
  assign hit_e       = rd_e[s1_col];

  always_comb begin
    mark_b = 1'b0;
    pass   = 1'b0;
    clear  = 1'b0;
    case (s1_kind)
      KIND_CLEAR: begin
        clear = s1_fire;
      end
      KIND_B: begin
        mark_b = s1_in_range;
        pass   = (mode == MODE_UNION);
      end
      KIND_A: begin
        case (mode)
          MODE_UNION:     pass = 1'b1;
          MODE_INTERSECT: pass = hit_b;
          MODE_DIFF:      pass = !hit_b;
          default:        pass = 1'b0;
        endcase
      end
      default: begin
        pass = 1'b0;
      end
    endcase
  end

  assign emit = s1_in_range && pass && !hit_e;

  assign wr.en  = s1_fire && s1_in_range && ((s1_kind == KIND_A) || (s1_kind == KIND_B));
  assign wr.row = s1_idx[IDX_W-1:COL_W];
  assign wr.b   = rd_b | (mark_b ? col_mask : '0);
  assign wr.e   = rd_e | (emit ? col_mask : '0);

  bsof_row_store u_store (
    .clk   (clk),
    .rst   (rst),
    .rd    (rd),
    .wr    (wr),
    .clear (clear),
    .rd_b  (rd_b),
    .rd_e  (rd_e)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_INTERSECT;
      count     <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        mode <= cfg_data;
      end
      if (s_axis_tready) begin
        s1_valid <= s_axis_tvalid;
      end
      if (s1_go) begin
        out_valid <= s1_fire && emit;
      end
      if (clear) begin
        count <= '0;
      end else if (s1_fire && emit) begin
        count <= count + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_kind  <= s_axis_tuser;
      s1_value <= s_axis_tdata[VALUE_W-1:0];
    end
    if (s1_fire && emit) begin
      out_value <= s1_value;
      out_pos   <= count;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_pos, out_value};

endmodule

>>> design/bsof_checker.sv
`include "bitmap_set_operation_filter_unit_macros.svh"

module bsof_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [bsof_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import bsof_pkg::*;

  // A result that is not taken stays on the bus unchanged.
  `BSOF_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // The input only stalls behind a result that the consumer is holding off.
  `BSOF_ASSERT_IMPLIES(a_stall_cause, clk, rst, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

  // Nothing is offered in the cycle after a reset.
  `BSOF_ASSERT_IMPLIES(a_reset_empty, clk, rst, $past(rst), !m_axis_tvalid)

  // The padding above the result fields is always zero.
  `BSOF_ASSERT_IMPLIES(a_out_pad, clk, rst, m_axis_tvalid, m_axis_tdata[OUT_TDATA_W-1:VALUE_W+POS_W] == '0)

endmodule

bind bitmap_set_operation_filter_unit bsof_checker u_bsof_checker (.*);

>>> dv/bitmap_set_operation_filter_unit_test.sv
module bitmap_set_operation_filter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bsof_pkg::*;

  // Encodings left unused by the package; no result comes of either.
  localparam kind_t KIND_UNUSED = 2'd3;
  localparam mode_t MODE_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1600;
  localparam int DRAIN_CYCLES = 8;

  typedef logic [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic [POS_W-1:0] position;
    value_t           value;
  } result_t;

  typedef struct packed {
    bit      is_cfg;
    mode_t   mode;
    kind_t   kind;
    value_t  value;
    bit      typed;
    bit      has;
    result_t res;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [KIND_W-1:0]      s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [MODE_W-1:0]      cfg_data = '0;

  // Expectation typed into the directed table, carried alongside each item.
  logic    item_typed = 1'b0;
  logic    item_has = 1'b0;
  result_t item_result = '0;

  // Private copy of the filter state.
  logic [VALUE_RANGE-1:0] member_b = '0;
  logic [VALUE_RANGE-1:0] emitted = '0;
  logic [POS_W-1:0]       result_total = '0;
  mode_t                  mode_now = MODE_INTERSECT;

  result_t   pending_results[$];
  stim_row_t directed_rows[$];
  int        mismatches = 0;
  int        quiet_left[2] = '{0, 0};

  always #5 clk = ~clk;

  bitmap_set_operation_filter_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  // Applies one item to the state copy; returns 1 with the result if one is emitted.
  function automatic bit filter_predict(input kind_t k, input value_t v, output result_t r);
    bit hit;
    hit = 1'b0;
    r = '0;
    if (k == KIND_CLEAR) begin
      member_b = '0;
      emitted = '0;
      result_total = '0;
      return 1'b0;
    end
    if (int'(v) >= VALUE_RANGE) begin
      return 1'b0;
    end
    if (k == KIND_B) begin
      member_b[v] = 1'b1;
      hit = (mode_now == MODE_UNION);
    end else if (k == KIND_A) begin
      case (mode_now)
        MODE_UNION:     hit = 1'b1;
        MODE_INTERSECT: hit = member_b[v];
        MODE_DIFF:      hit = !member_b[v];
        default:        hit = 1'b0;
      endcase
    end
    if (!hit || emitted[v]) begin
      return 1'b0;
    end
    emitted[v] = 1'b1;
    r.value = v;
    r.position = result_total;
    result_total = result_total + 1'b1;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    result_t predicted;
    bit      emits;
    if (rst) begin
      member_b = '0;
      emitted = '0;
      result_total = '0;
      mode_now = MODE_INTERSECT;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.value = m_axis_tdata[VALUE_W-1:0];
        got.position = m_axis_tdata[VALUE_W+POS_W-1:VALUE_W];
        if (pending_results.size() == 0) begin
          note_mismatch($sformatf("result %0d at position %0d with nothing pending",
                                  got.value, got.position));
        end else begin
          want = pending_results.pop_front();
          if (got.value !== want.value) begin
            note_mismatch($sformatf("result_value expected %0d got %0d",
                                    want.value, got.value));
          end
          if (got.position !== want.position) begin
            note_mismatch($sformatf("result_position expected %0d got %0d",
                                    want.position, got.position));
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        emits = filter_predict(s_axis_tuser, s_axis_tdata[VALUE_W-1:0], predicted);
        if (item_typed) begin
          emits = item_has;
          predicted = item_result;
        end
        if (emits) begin
          pending_results.push_back(predicted);
        end
      end
      if (cfg_valid && cfg_ready) begin
        mode_now = cfg_data;
      end
    end
  end

  // Draws a random wait between transfers, with occasional runs of back-to-back transfers.
  function automatic int pick_gap(input int side);
    if (quiet_left[side] > 0) begin
      quiet_left[side]--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet_left[side] = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 3);
  endfunction

  initial begin
    int gap;
    forever begin
      gap = pick_gap(1);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  task automatic send_item(input kind_t k, input value_t v, input bit typed, input bit has,
                           input result_t r);
    int gap;
    gap = pick_gap(0);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= k;
    s_axis_tdata <= {{(IN_TDATA_W-VALUE_W){1'b0}}, v};
    item_typed <= typed;
    item_has <= has;
    item_result <= r;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic send_pred(input kind_t k, input value_t v);
    send_item(k, v, 1'b0, 1'b0, '0);
  endtask

  // Waits until every expected result has come, then lets the pipeline empty.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input mode_t m);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic void row_mode(input mode_t m);
    stim_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.mode = m;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_pred(input kind_t k, input value_t v);
    stim_row_t row;
    row = '0;
    row.kind = k;
    row.value = v;
    directed_rows.push_back(row);
  endfunction

  function automatic void row_typed(input kind_t k, input value_t v, input bit has,
                                    input int pos);
    stim_row_t row;
    row = '0;
    row.kind = k;
    row.value = v;
    row.typed = 1'b1;
    row.has = has;
    if (has) begin
      row.res.value = v;
      row.res.position = POS_W'(pos);
    end
    directed_rows.push_back(row);
  endfunction

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int     sent;
    int     phase;
    int     phase_end;
    int     span;
    int     base;
    int     nb;
    int     na;
    kind_t  k;
    value_t v;
    mode_t  m;

    // Intersection right after reset: A only passes once B has marked it.
    row_typed(KIND_A, 10'd0, 1'b0, 0);
    row_pred(KIND_B, 10'd0);
    row_pred(KIND_B, 10'd1023);
    row_typed(KIND_A, 10'd0, 1'b1, 0);
    row_typed(KIND_A, 10'd0, 1'b0, 0);
    row_typed(KIND_A, 10'd1023, 1'b1, 1);
    row_pred(KIND_A, 10'd7);
    row_typed(KIND_UNUSED, 10'd1023, 1'b0, 0);
    row_typed(KIND_CLEAR, 10'd1023, 1'b0, 0);
    row_typed(KIND_A, 10'd0, 1'b0, 0);
    // Union: B elements are emitted too, still without duplicates.
    row_mode(MODE_UNION);
    row_typed(KIND_B, 10'd1023, 1'b1, 0);
    row_typed(KIND_A, 10'd1023, 1'b0, 0);
    row_typed(KIND_A, 10'd0, 1'b1, 1);
    row_pred(KIND_B, 10'd0);
    row_pred(KIND_A, 10'h2AA);
    row_pred(KIND_B, 10'h155);
    row_mode(MODE_DIFF);
    row_pred(KIND_CLEAR, 10'd0);
    row_pred(KIND_B, 10'd5);
    row_typed(KIND_A, 10'd5, 1'b0, 0);
    row_typed(KIND_A, 10'd6, 1'b1, 0);
    row_typed(KIND_A, 10'd6, 1'b0, 0);
    // The unused mode only marks B and never emits.
    row_mode(MODE_UNUSED);
    row_pred(KIND_CLEAR, 10'd0);
    row_typed(KIND_B, 10'd9, 1'b0, 0);
    row_typed(KIND_A, 10'd9, 1'b0, 0);
    row_typed(KIND_A, 10'd10, 1'b0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        write_mode(directed_rows[i].mode);
      end else begin
        send_item(directed_rows[i].kind, directed_rows[i].value, directed_rows[i].typed,
                  directed_rows[i].has, directed_rows[i].res);
      end
    end

    // Random jobs: mostly a clear, then B elements, then A elements drawn from a window so
    // that values overlap, with some noise mixed in.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase % 4)
        0:       m = MODE_INTERSECT;
        1:       m = MODE_UNION;
        2:       m = MODE_DIFF;
        default: m = mode_t'($urandom_range(0, 3));
      endcase
      write_mode(m);
      phase_end = sent + $urandom_range(120, 280);
      while (sent < phase_end && sent < RANDOM_ITEMS) begin
        if ($urandom_range(0, 7) != 0) begin
          send_pred(KIND_CLEAR, VALUE_W'($urandom));
          sent++;
        end
        case ($urandom_range(0, 2))
          0:       span = 15;
          1:       span = 63;
          default: span = VALUE_RANGE - 1;
        endcase
        base = $urandom_range(0, VALUE_RANGE - 1 - span);
        nb = $urandom_range(0, 20);
        na = $urandom_range(0, 30);
        for (int j = 0; j < nb + na; j++) begin
          k = (j < nb) ? KIND_B : KIND_A;
          v = VALUE_W'(base + $urandom_range(0, span));
          if ($urandom_range(0, 9) == 0) begin
            k = kind_t'($urandom_range(0, 3));
            v = VALUE_W'($urandom);
          end
          send_pred(k, v);
          if (k != KIND_UNUSED) begin
            sent++;
          end
        end
      end
      phase++;
    end

    wait_drained();
    if (pending_results.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
